FILE: rtl/core/four_level_page_table_walker_top_macros.svh
// Assertion macros for the four-level page table walker.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ptw_pkg.sv
// Shared types, codes and helper functions for the page table walker.
// No dependencies; used by every module of the walker.
`timescale 1ns / 1ps

package ptw_pkg;

	localparam int PA_W      = 52;
	localparam int VA_W      = 48;
	localparam int DATA_W    = 64;
	localparam int LIMIT_W   = 41;
	localparam int IDX_W     = 9;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = 2;
	localparam int Q_CNT_W   = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 4;
	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 176;

	localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 41'd1048576;

	typedef enum logic {
		REG_CURRENT_ROOT = 1'b0,
		REG_FRAME_LIMIT  = 1'b1
	} reg_sel_t;

	typedef enum logic {
		FUNC_REQ  = 1'b0,
		FUNC_RESP = 1'b1
	} func_t;

	typedef enum logic {
		KIND_READ  = 1'b0,
		KIND_FINAL = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO_ADDR = 3'd1,
		ST_BAD_ROOT  = 3'd2,
		ST_NO_PML4E  = 3'd3,
		ST_NO_PDPTE  = 3'd4,
		ST_HUGE_1G   = 3'd5,
		ST_NO_PDE    = 3'd6,
		ST_NO_PTE    = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		LVL_PML4 = 2'd0,
		LVL_PDPT = 2'd1,
		LVL_PD   = 2'd2,
		LVL_PT   = 2'd3
	} level_t;

	// Classified input item as it sits in the queue.
	typedef struct packed {
		func_t              func;
		logic [VA_W-1:0]    vaddr;
		status_t            code;
		logic [PA_W-1:0]    entry_addr;
		logic [DATA_W-1:0]  read_data;
	} ptw_item_t;

	typedef struct packed {
		kind_t              kind;
		logic [PA_W-1:0]    read_addr;
		status_t            status;
		logic [PA_W-1:0]    entry_addr;
		logic [DATA_W-1:0]  entry_value;
		logic               leaf_2m;
	} ptw_result_t;

	typedef struct packed {
		logic [PA_W-1:0]    current_root;
		logic [LIMIT_W-1:0] frame_limit;
	} ptw_cfg_t;

	function automatic logic [PA_W-1:0] frame_mask(input int phys_bits);
		logic [PA_W-1:0] m;
		m = {PA_W{1'b1}} >> (PA_W - phys_bits);
		return m & ~{{(PA_W-12){1'b0}}, 12'hFFF};
	endfunction

	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
			input level_t lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			LVL_PML4: idx = va[47:39];
			LVL_PDPT: idx = va[38:30];
			LVL_PD:   idx = va[29:21];
			LVL_PT:   idx = va[20:12];
			default:  idx = '0;
		endcase
		return idx;
	endfunction

	// Base has bits 11:0 clear, so the 8-byte entry offset is merged by OR.
	function automatic logic [PA_W-1:0] entry_at(input logic [PA_W-1:0] base,
			input logic [IDX_W-1:0] idx, input logic [PA_W-1:0] mask);
		return (base & mask) | {{(PA_W-IDX_W-3){1'b0}}, idx, 3'b000};
	endfunction

	function automatic status_t absent_status(input level_t lvl);
		status_t st;
		case (lvl)
			LVL_PML4: st = ST_NO_PML4E;
			LVL_PDPT: st = ST_NO_PDPTE;
			LVL_PD:   st = ST_NO_PDE;
			LVL_PT:   st = ST_NO_PTE;
			default:  st = ST_NO_PTE;
		endcase
		return st;
	endfunction

endpackage

FILE: rtl/core/ptw_queue.sv
// Small in-order queue of classified items between the front and the back.
// Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ptw_pkg::ptw_item_t  push_item,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output ptw_pkg::ptw_item_t  head_item
);
	import ptw_pkg::*;

	ptw_item_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]    wr_ptr_q;
	logic [Q_PTR_W-1:0]    rd_ptr_q;
	logic [Q_CNT_W-1:0]    count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full       = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/ptw_front.sv
// Front end: accepts input items, decodes them and pre-checks requests
// (zero address, root selection and range). Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_front #(
	parameter int PHYS_ADDR_BITS = 52
) (
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ptw_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	input  ptw_pkg::ptw_cfg_t                  cfg,
	input  logic                               q_full,
	output logic                               push,
	output ptw_pkg::ptw_item_t                 item
);
	import ptw_pkg::*;

	localparam logic [PA_W-1:0] FrameMask = frame_mask(PHYS_ADDR_BITS);

	logic [VA_W-1:0]   va;
	logic [PA_W-1:0]   root;
	logic [PA_W-1:0]   root_sel;
	logic              out_of_range;
	logic              base_zero;

	assign va   = s_tdata[47:0];
	assign root = s_tdata[99:48];

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		root_sel     = (root == '0) ? cfg.current_root : root;
		out_of_range = (root != '0) && ({1'b0, root[51:12]} >= cfg.frame_limit);
		base_zero    = ((root_sel & FrameMask) == '0);

		item.func       = func_t'(s_tuser);
		item.vaddr      = va;
		item.read_data  = s_tdata[163:100];
		item.entry_addr = entry_at(root_sel, level_index(va, LVL_PML4), FrameMask);
		if (va == '0) begin
			item.code = ST_ZERO_ADDR;
		end else if (out_of_range || base_zero) begin
			item.code = ST_BAD_ROOT;
		end else begin
			item.code = ST_OK;
		end
	end

endmodule

FILE: rtl/core/ptw_back.sv
// Back end: holds the walk state, consumes queued items in order and
// drives the registered result. Depends on ptw_pkg and the macro header.
`timescale 1ns / 1ps
`include "four_level_page_table_walker_top_macros.svh"

module ptw_back #(
	parameter int PHYS_ADDR_BITS = 52
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  ptw_pkg::ptw_item_t    head_item,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ptw_pkg::ptw_result_t  res
);
	import ptw_pkg::*;

	localparam logic [PA_W-1:0] FrameMask = frame_mask(PHYS_ADDR_BITS);

	logic              busy_q;
	level_t            level_q;
	logic [VA_W-1:0]   vaddr_q;
	logic [PA_W-1:0]   pending_q;
	logic              out_valid_q;
	ptw_result_t       out_q;

	logic              busy_d;
	level_t            level_d;
	logic [VA_W-1:0]   vaddr_d;
	logic [PA_W-1:0]   pending_d;
	logic              has_res;
	ptw_result_t       res_d;
	logic              out_free;
	logic              push;
	logic              present;
	logic              ps_bit;
	level_t            level_nx;
	logic [PA_W-1:0]   next_addr;

	assign out_free  = !out_valid_q || res_ready;
	assign pop       = head_valid && (!has_res || out_free);
	assign push      = pop && has_res;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		present   = head_item.read_data[0];
		ps_bit    = head_item.read_data[7];
		level_nx  = level_t'(level_q + 2'd1);
		next_addr = entry_at({head_item.read_data[51:12], 12'h000},
			level_index(vaddr_q, level_nx), FrameMask);

		busy_d    = busy_q;
		level_d   = level_q;
		vaddr_d   = vaddr_q;
		pending_d = pending_q;
		has_res   = 1'b0;
		res_d     = '0;

		if (head_item.func == FUNC_REQ) begin
			if (!busy_q) begin
				has_res = 1'b1;
				if (head_item.code != ST_OK) begin
					res_d.kind   = KIND_FINAL;
					res_d.status = head_item.code;
				end else begin
					busy_d          = 1'b1;
					level_d         = LVL_PML4;
					vaddr_d         = head_item.vaddr;
					pending_d       = head_item.entry_addr;
					res_d.kind      = KIND_READ;
					res_d.read_addr = head_item.entry_addr;
				end
			end
		end else if (busy_q) begin
			has_res    = 1'b1;
			res_d.kind = KIND_FINAL;
			busy_d     = 1'b0;
			level_d    = LVL_PML4;
			if (!present) begin
				res_d.status = absent_status(level_q);
			end else if (level_q == LVL_PDPT && ps_bit) begin
				res_d.status = ST_HUGE_1G;
			end else if ((level_q == LVL_PD && ps_bit) || level_q == LVL_PT) begin
				res_d.status      = ST_OK;
				res_d.entry_addr  = pending_q;
				res_d.entry_value = head_item.read_data;
				res_d.leaf_2m     = (level_q == LVL_PD);
			end else begin
				// Descend one level.
				busy_d          = 1'b1;
				level_d         = level_nx;
				pending_d       = next_addr;
				res_d.kind      = KIND_READ;
				res_d.read_addr = next_addr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			level_q     <= LVL_PML4;
			vaddr_q     <= '0;
			pending_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q    <= busy_d;
				level_q   <= level_d;
				vaddr_q   <= vaddr_d;
				pending_q <= pending_d;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res_d;
		end
	end

	`PTW_ASSERT_NEXT(a_final_ends_walk, clk, arst_n, push && res_d.kind == KIND_FINAL, !busy_q, "final result left the walker busy")
	`PTW_ASSERT_NEXT(a_read_keeps_walk, clk, arst_n, push && res_d.kind == KIND_READ, busy_q, "read request issued without an active walk")
	`PTW_ASSERT_SAME(a_idle_resp_dropped, clk, arst_n, pop && head_item.func == FUNC_RESP && !busy_q, !push, "response while idle produced a result")
	`PTW_ASSERT_SAME(a_pending_aligned, clk, arst_n, busy_q, pending_q[2:0] == 3'b000, "pending entry address not 8-byte aligned")

endmodule

FILE: rtl/core/four_level_page_table_walker_top.sv
// Top level of the four-level page table walker: configuration registers,
// front end, item queue and walk back end. Depends on ptw_pkg and submodules.
//
// Usage:
//  - Input channel s_*: s_tuser is the item type (0 translation request,
//    1 memory read response). Requests carry the virtual address and a root
//    address, where a zero root selects the configured current root;
//    responses carry read_data, the 64-bit table entry read from memory.
//  - Output channel m_*: m_tuser is the result kind (0 memory read request,
//    1 final walk result). A read request gives read_addr; the memory's
//    answer must come back on the input channel as a response item.
//  - Each accepted item yields at most one result; m_tvalid rises only once
//    it has passed the queue and the output register. One item per cycle is
//    sustained while m_tready is high, the back end evaluating one queued item.
//  - A 4 KiB walk costs four memory round trips, a 2 MiB walk three.
//  - When m_tready is low the result is held in the output register and the
//    four-entry queue keeps accepting items until it fills; then s_tready
//    drops. Items that give no result drain even while the output stalls.
//  - Reset empties the queue, walk state and output; current_root 0, frame_limit 1048576.
//  - APB: current_root at 0x0, frame_limit at 0x8; pready is always high.
`timescale 1ns / 1ps

module four_level_page_table_walker_top #(
	parameter int PHYS_ADDR_BITS = 52
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input items
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [47:0] vaddr, [99:48] root_addr, [163:100] read_data, rest zero
	input  logic [ptw_pkg::IN_DATA_W-1:0]      s_tdata,
	// [0] func
	input  logic                               s_tuser,
	// Result items
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [51:0] read_addr, [54:52] status, [106:55] entry_addr,
	// [170:107] entry_value, [171] leaf_2m, rest zero
	output logic [ptw_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] kind
	output logic                               m_tuser,
	// Configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ptw_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [ptw_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [ptw_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import ptw_pkg::*;

	ptw_cfg_t     cfg_q;
	logic         cfg_wr;
	reg_sel_t     reg_sel;

	logic         q_full;
	logic         q_push;
	ptw_item_t    q_in;
	logic         q_pop;
	logic         q_head_valid;
	ptw_item_t    q_head;
	ptw_result_t  res;

	// Registers decode on address bit 3 alone; byte offsets are ignored.
	assign pready  = 1'b1;
	assign reg_sel = reg_sel_t'(paddr[3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_CURRENT_ROOT: prdata = {{(CFG_DATA_W-PA_W){1'b0}}, cfg_q.current_root};
			REG_FRAME_LIMIT:  prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, cfg_q.frame_limit};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_root <= '0;
			cfg_q.frame_limit  <= FRAME_LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_CURRENT_ROOT: cfg_q.current_root <= pwdata[PA_W-1:0];
				REG_FRAME_LIMIT:  cfg_q.frame_limit  <= pwdata[LIMIT_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// Decode and pre-check requests before they enter the queue.
	ptw_front #(
		.PHYS_ADDR_BITS (PHYS_ADDR_BITS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (q_push),
		.item     (q_in)
	);

	// Decouple acceptance from the walk so either side may stall.
	ptw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_item  (q_head)
	);

	// Walk engine and output register.
	ptw_back #(
		.PHYS_ADDR_BITS (PHYS_ADDR_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_item  (q_head),
		.pop        (q_pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	// Pack the result fields, lowest field first.
	assign m_tuser = res.kind;
	assign m_tdata = {4'b0000, res.leaf_2m, res.entry_value, res.entry_addr,
		res.status, res.read_addr};

endmodule

FILE: verif/four_level_page_table_walker_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the four-level page table walker top level.
// Plays the memory that answers the walker's reads and predicts every result
// on its own; depends only on ptw_pkg and four_level_page_table_walker_top.

module four_level_page_table_walker_top_tb;

	import ptw_pkg::*;

	localparam int PHYS_BITS = 52;
	// Table base bits kept from a root or an entry: 11:0 clear, cut to PHYS_BITS.
	localparam logic [PA_W-1:0] BASE_MASK = ({PA_W{1'b1}} >> (PA_W - PHYS_BITS)) &
		~{{(PA_W-12){1'b0}}, 12'hFFF};
	// Cycles to let items that yield nothing drain out of the queue.
	localparam int SETTLE_CYCLES = 16;
	localparam logic [LIMIT_W-1:0] LIMIT_MAX = 41'h100_0000_0000;

	logic                      clk;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	// [47:0] vaddr, [99:48] root_addr, [163:100] read_data, rest zero
	logic [IN_DATA_W-1:0]      s_tdata;
	// [0] func
	logic                      s_tuser;
	logic                      m_tvalid;
	logic                      m_tready;
	// [51:0] read_addr, [54:52] status, [106:55] entry_addr,
	// [170:107] entry_value, [171] leaf_2m, rest zero
	logic [OUT_DATA_W-1:0]     m_tdata;
	// [0] kind
	logic                      m_tuser;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [CFG_ADDR_W-1:0]     paddr;
	logic [CFG_DATA_W-1:0]     pwdata;
	logic [CFG_DATA_W-1:0]     prdata;
	logic                      pready;

	// Shadow of the configuration registers.
	logic [PA_W-1:0]           root_reg;
	logic [LIMIT_W-1:0]        limit_reg;

	// Walk state as the walker should hold it.
	logic                      walker_busy;
	level_t                    walker_level;
	logic [VA_W-1:0]           walker_vaddr;
	logic [PA_W-1:0]           walker_entry_addr;

	// Results predicted at item acceptance, oldest first.
	ptw_result_t               due_results[$];
	int                        result_cnt;
	int                        fail_cnt;

	// Knobs for the idling processes; hold_cycles forces a long output stall.
	int                        send_idle_pct;
	int                        recv_stall_pct;
	int                        hold_cycles;

	four_level_page_table_walker_top #(
		.PHYS_ADDR_BITS(PHYS_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the walker hangs or loses a result.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Table index of one level: vaddr bits 47:39, 38:30, 29:21, 20:12.
	function automatic logic [8:0] va_slice(input logic [VA_W-1:0] va, input level_t l);
		return va[(47 - 9 * int'(l)) -: 9];
	endfunction

	task automatic note_failure(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got)
			note_failure($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
	endtask

	// Advance the walk by one accepted item and work out the result it causes.
	task automatic walk_step(input func_t f, input logic [VA_W-1:0] va,
			input logic [PA_W-1:0] root, input logic [DATA_W-1:0] data,
			output bit produced, output ptw_result_t r);
		logic [PA_W-1:0] sel_root;
		logic [PA_W-1:0] base;
		r = '0;
		r.kind = KIND_FINAL;
		r.status = ST_OK;
		produced = 1'b0;
		if (f == FUNC_REQ) begin
			// A new request is dropped while a walk is under way.
			if (walker_busy)
				return;
			produced = 1'b1;
			if (va == '0) begin
				r.status = ST_ZERO_ADDR;
				return;
			end
			sel_root = root;
			if (root == '0) begin
				sel_root = root_reg;
			end else if ({1'b0, root[PA_W-1:12]} >= limit_reg) begin
				r.status = ST_BAD_ROOT;
				return;
			end
			base = sel_root & BASE_MASK;
			if (base == '0) begin
				r.status = ST_BAD_ROOT;
				return;
			end
			walker_busy = 1'b1;
			walker_level = LVL_PML4;
			walker_vaddr = va;
			walker_entry_addr = base | {va_slice(va, LVL_PML4), 3'b000};
			r.kind = KIND_READ;
			r.read_addr = walker_entry_addr;
			return;
		end
		// A memory answer with no walk to feed is dropped.
		if (!walker_busy)
			return;
		produced = 1'b1;
		if (!data[0]) begin
			case (walker_level)
				LVL_PML4: r.status = ST_NO_PML4E;
				LVL_PDPT: r.status = ST_NO_PDPTE;
				LVL_PD:   r.status = ST_NO_PDE;
				default:  r.status = ST_NO_PTE;
			endcase
		end else if (walker_level == LVL_PDPT && data[7]) begin
			r.status = ST_HUGE_1G;
		end else if ((walker_level == LVL_PD && data[7]) || walker_level == LVL_PT) begin
			r.entry_addr = walker_entry_addr;
			r.entry_value = data;
			r.leaf_2m = (walker_level == LVL_PD);
		end else begin
			walker_level = level_t'(walker_level + 2'd1);
			walker_entry_addr = (data[PA_W-1:0] & BASE_MASK) |
				{va_slice(walker_vaddr, walker_level), 3'b000};
			r.kind = KIND_READ;
			r.read_addr = walker_entry_addr;
			return;
		end
		// Any final result closes the walk.
		walker_busy = 1'b0;
		walker_level = LVL_PML4;
	endtask

	// Offer one item, idling first at the current rate, and predict its result
	// once accepted. Valid stays high after acceptance until the next call or
	// until drain_results drops it.
	task automatic send_item(input func_t f, input logic [VA_W-1:0] va,
			input logic [PA_W-1:0] root, input logic [DATA_W-1:0] data);
		bit produced;
		ptw_result_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= {4'b0, data, root, va};
		do
			@(posedge clk);
		while (!s_tready);
		walk_step(f, va, root, data, produced, r);
		if (produced) begin
			due_results.push_back(r);
			result_cnt++;
		end
	endtask

	// Drop valid and wait until every predicted result has come back, then
	// let ignored items drain so the registers may be touched safely.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_check(input reg_sel_t r, input logic [63:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {r, 3'b000};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		check_field(r == REG_CURRENT_ROOT ? "current_root read" : "frame_limit read",
			want, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write a register, mirror it in the shadow and read it back.
	task automatic reg_write(input reg_sel_t r, input logic [63:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 3'b000};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (r == REG_CURRENT_ROOT) begin
			root_reg = v[PA_W-1:0];
			reg_check(r, 64'(root_reg));
		end else begin
			limit_reg = v[LIMIT_W-1:0];
			reg_check(r, 64'(limit_reg));
		end
	endtask

	function automatic logic [VA_W-1:0] pick_vaddr();
		if ($urandom_range(0, 99) < 2)
			return '0;
		return VA_W'(rand64());
	endfunction

	// Mostly the configured root or a valid foreign one, some out of range.
	function automatic logic [PA_W-1:0] pick_root();
		int p;
		logic [63:0] frame;
		p = $urandom_range(0, 99);
		if (p < 40)
			return '0;
		if (p < 75 && limit_reg != '0) begin
			frame = rand64() % 64'(limit_reg);
			return {frame[39:0], 12'($urandom)};
		end
		if (p < 85 && limit_reg < LIMIT_MAX) begin
			frame = 64'(limit_reg) + rand64() % (64'(LIMIT_MAX) - 64'(limit_reg));
			return {frame[39:0], 12'($urandom)};
		end
		return PA_W'(rand64());
	endfunction

	// Entry as memory returns it: mostly present, page-size bit biased per level.
	function automatic logic [DATA_W-1:0] table_entry(input level_t l);
		logic [DATA_W-1:0] e;
		e = rand64();
		e[0] = ($urandom_range(0, 99) >= 8);
		if (l == LVL_PDPT)
			e[7] = ($urandom_range(0, 99) < 12);
		else if (l == LVL_PD)
			e[7] = ($urandom_range(0, 99) < 35);
		return e;
	endfunction

	// Walk that ends at stop_lvl, there absent or with the page-size bit set.
	task automatic directed_walk(input logic [VA_W-1:0] va, input level_t stop_lvl,
			input bit absent, input bit ps);
		logic [DATA_W-1:0] e;
		send_item(FUNC_REQ, va, '0, rand64());
		while (walker_busy) begin
			e = rand64();
			e[0] = 1'b1;
			if (walker_level == LVL_PDPT || walker_level == LVL_PD)
				e[7] = 1'b0;
			if (walker_level == stop_lvl) begin
				e[0] = ~absent;
				e[7] = ps;
			end
			send_item(FUNC_RESP, VA_W'(rand64()), PA_W'(rand64()), e);
		end
	endtask

	// One random sequence: mostly a complete walk, some cut short, some noise.
	task automatic random_episode();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			send_item(FUNC_REQ, pick_vaddr(), pick_root(), rand64());
			while (walker_busy) begin
				// Throw in a request that must be dropped mid-walk.
				if ($urandom_range(0, 99) < 5)
					send_item(FUNC_REQ, pick_vaddr(), pick_root(), rand64());
				send_item(FUNC_RESP, VA_W'(rand64()), PA_W'(rand64()),
					table_entry(walker_level));
			end
		end else if (pick < 88) begin
			send_item(FUNC_REQ, pick_vaddr(), pick_root(), rand64());
			repeat ($urandom_range(0, 2))
				send_item(FUNC_RESP, VA_W'(rand64()), PA_W'(rand64()),
					table_entry(walker_level));
		end else begin
			send_item(func_t'($urandom_range(0, 1)), VA_W'(rand64()), PA_W'(rand64()),
				rand64());
		end
	endtask

	task automatic random_phase(input int target, input int idle_pct, input int stall_p);
		int start_cnt;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_p;
		start_cnt = result_cnt;
		while (result_cnt - start_cnt < target)
			random_episode();
		drain_results();
	endtask

	// Reset values, then every way a request can fail before the first read.
	task automatic test_reset_and_errors();
		logic [63:0] frame;
		reg_check(REG_CURRENT_ROOT, 64'd0);
		reg_check(REG_FRAME_LIMIT, 64'(FRAME_LIMIT_RST));
		// Configured root still zero.
		send_item(FUNC_REQ, VA_W'(rand64()) | 48'h1000, '0, rand64());
		send_item(FUNC_REQ, '0, PA_W'(rand64()), rand64());
		// Memory answer with no walk running.
		send_item(FUNC_RESP, VA_W'(rand64()), PA_W'(rand64()), rand64());
		drain_results();
		// Nonzero root whose base is zero after the low bits are cleared.
		reg_write(REG_CURRENT_ROOT, 64'hFFF);
		send_item(FUNC_REQ, VA_W'(rand64()) | 48'h1, '0, rand64());
		drain_results();
		frame = 64'($urandom_range(1, 32'h000F_FFFF));
		reg_write(REG_CURRENT_ROOT, {12'b0, frame[39:0], 12'($urandom)});
		// Foreign root right at the frame limit, then one in frame zero.
		send_item(FUNC_REQ, VA_W'(rand64()) | 48'h1, {40'(limit_reg), 12'h0}, rand64());
		send_item(FUNC_REQ, VA_W'(rand64()) | 48'h1, 52'hABC, rand64());
		drain_results();
	endtask

	// Walks that end absent at PML4 and PD, in a 1 GiB and a 2 MiB page, and a full one at the field extremes.
	task automatic test_walk_outcomes();
		directed_walk(VA_W'(rand64()) | 48'h1, LVL_PML4, 1'b1, 1'b0);
		directed_walk(VA_W'(rand64()) | 48'h1, LVL_PDPT, 1'b0, 1'b1);
		directed_walk(VA_W'(rand64()) | 48'h1, LVL_PD, 1'b1, 1'b0);
		directed_walk(VA_W'(rand64()) | 48'h1, LVL_PD, 1'b0, 1'b1);
		// All-ones address and PML4 and PT entries; a request lands while busy and is dropped.
		send_item(FUNC_REQ, '1, '0, rand64());
		send_item(FUNC_RESP, VA_W'(rand64()), PA_W'(rand64()), '1);
		send_item(FUNC_REQ, VA_W'(rand64()) | 48'h1, '0, rand64());
		send_item(FUNC_RESP, VA_W'(rand64()), PA_W'(rand64()), ~64'h80);
		send_item(FUNC_RESP, VA_W'(rand64()), PA_W'(rand64()), ~64'h80);
		send_item(FUNC_RESP, VA_W'(rand64()), PA_W'(rand64()), '1);
		drain_results();
	endtask

	task automatic test_smooth_flow();
		reg_write(REG_CURRENT_ROOT, 64'(PA_W'(rand64())));
		reg_write(REG_FRAME_LIMIT, 64'(FRAME_LIMIT_RST));
		random_phase(180, 0, 0);
	endtask

	// Widest root and every 40-bit frame valid.
	task automatic test_sender_gaps();
		reg_write(REG_CURRENT_ROOT, 64'h000F_FFFF_FFFF_FFFF);
		reg_write(REG_FRAME_LIMIT, 64'(LIMIT_MAX));
		random_phase(180, 74, 0);
	endtask

	// No foreign root valid at all.
	task automatic test_receiver_stalls();
		reg_write(REG_CURRENT_ROOT, 64'(PA_W'(rand64())));
		reg_write(REG_FRAME_LIMIT, 64'd0);
		random_phase(180, 0, 74);
	endtask

	task automatic test_mixed_idling();
		reg_write(REG_CURRENT_ROOT, 64'(PA_W'(rand64())));
		reg_write(REG_FRAME_LIMIT, 64'(rand64() % 64'(LIMIT_MAX)) + 64'd1);
		random_phase(180, 27, 27);
	endtask

	// Hold the output off long enough for the queue to fill and s_tready to
	// drop, then let the sender sit idle until every result is home.
	task automatic test_backpressure();
		reg_write(REG_CURRENT_ROOT, 64'(PA_W'(rand64())));
		reg_write(REG_FRAME_LIMIT, 64'd1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 300;
		repeat (30) random_episode();
		drain_results();
		repeat (30) random_episode();
		drain_results();
	endtask

	// Output side: random stalls at the phase's rate, or a counted hold-off.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Compare each result item against the oldest prediction, field by field.
	always @(posedge clk) begin : result_check
		ptw_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_results.size() == 0) begin
				note_failure($sformatf("result with none due: kind %0d data 0x%0h",
					m_tuser, m_tdata));
			end else begin
				want = due_results.pop_front();
				check_field("kind", 64'(want.kind), 64'(m_tuser));
				check_field("read_addr", 64'(want.read_addr), 64'(m_tdata[51:0]));
				check_field("status", 64'(want.status), 64'(m_tdata[54:52]));
				check_field("entry_addr", 64'(want.entry_addr), 64'(m_tdata[106:55]));
				check_field("entry_value", want.entry_value, m_tdata[170:107]);
				check_field("leaf_2m", 64'(want.leaf_2m), 64'(m_tdata[171]));
			end
		end
	end

	initial begin
		// Park every input at a known value while reset is held.
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		root_reg = '0;
		limit_reg = FRAME_LIMIT_RST;
		walker_busy = 1'b0;
		walker_level = LVL_PML4;
		walker_vaddr = '0;
		walker_entry_addr = '0;
		result_cnt = 0;
		fail_cnt = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_and_errors();
		test_walk_outcomes();
		test_smooth_flow();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_idling();
		test_backpressure();

		// Every result is in; let the pipe run on idle so late misbehaviour shows.
		drain_results();
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: four_level_page_table_walker_top.f
+incdir+rtl/core
rtl/core/ptw_pkg.sv
rtl/core/ptw_queue.sv
rtl/core/ptw_front.sv
rtl/core/ptw_back.sv
rtl/core/four_level_page_table_walker_top.sv
verif/four_level_page_table_walker_top_tb.sv
